/* design/pfd_pkg.sv */
// Package for the padded frame deframer: phase codes, the parser state and
// result types, and the reset value of the frame limit register.
// No dependencies.
`default_nettype none

package pfd_pkg;

  // Parser phase codes.
  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_PAD_LEN = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_PADDING = 3'd4,
    PH_PASS    = 3'd5
  } pfd_phase_e;

  // Complete parser state, held in one register in the top level.
  typedef struct packed {
    pfd_phase_e  phase;
    logic [15:0] payload_length;
    logic [15:0] payload_received;
    logic [7:0]  padding_remaining;
    logic [7:0]  frames_seen;
  } pfd_state_t;

  // Result of parsing one byte; valid is low when the byte gives no output.
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       frame_payload_end;
    logic       is_passthrough;
  } pfd_result_t;

  localparam logic [7:0] PadLimitReset = 8'd8;

endpackage

`default_nettype wire

/* design/pfd_stream_if.sv */
// Channel interfaces of the padded frame deframer: input bytes, results and
// the limit register write channel. Valid/ready handshake on each.
// No dependencies.
`default_nettype none

// Input byte channel.
interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface pfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_payload_end;
  logic       is_passthrough;

  modport source (output valid, output out_byte, output frame_payload_end,
                  output is_passthrough, input ready);
  modport sink (input valid, input out_byte, input frame_payload_end,
                input is_passthrough, output ready);
endinterface

// Write channel for the padded frame limit register.
interface pfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] padded_frame_limit;

  modport source (output valid, output padded_frame_limit, input ready);
  modport sink (input valid, input padded_frame_limit, output ready);
endinterface

`default_nettype wire

/* design/pfd_parser.sv */
// Next-state and result logic of the padded frame deframer for one byte.
// Depends on pfd_pkg.
`default_nettype none

module pfd_parser
  import pfd_pkg::*;
(
  input  wire logic [7:0]  byte_i,
  input  wire pfd_state_t  state_i,
  input  wire logic [7:0]  limit_i,
  output pfd_state_t       state_o,
  output pfd_result_t      result_o
);

  logic        frame_done;
  logic [15:0] recv_inc;
  logic [7:0]  pad_dec;
  logic [8:0]  frames_inc;

  assign recv_inc   = state_i.payload_received + 16'd1;
  assign pad_dec    = state_i.padding_remaining - 8'd1;
  assign frames_inc = {1'b0, state_i.frames_seen} + 9'd1;

  // Per-phase handling of the incoming byte.
  always_comb begin
    state_o             = state_i;
    result_o            = '0;
    result_o.out_byte   = byte_i;
    frame_done          = 1'b0;

    case (state_i.phase)
      PH_PASS: begin
        result_o.valid          = 1'b1;
        result_o.is_passthrough = 1'b1;
      end
      PH_LEN_LO: begin
        state_o.payload_length[7:0] = byte_i;
        state_o.phase               = PH_PAD_LEN;
      end
      PH_PAD_LEN: begin
        state_o.padding_remaining = byte_i;
        state_o.payload_received  = '0;
        if (state_i.payload_length != 16'd0) begin
          state_o.phase = PH_PAYLOAD;
        end else if (byte_i != 8'd0) begin
          state_o.phase = PH_PADDING;
        end else begin
          frame_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        result_o.valid           = 1'b1;
        state_o.payload_received = recv_inc;
        if (recv_inc == state_i.payload_length) begin
          result_o.frame_payload_end = 1'b1;
          state_o.payload_received   = '0;
          if (state_i.padding_remaining == 8'd0) begin
            frame_done = 1'b1;
          end else begin
            state_o.phase = PH_PADDING;
          end
        end
      end
      PH_PADDING: begin
        state_o.padding_remaining = pad_dec;
        if (pad_dec == 8'd0) begin
          frame_done = 1'b1;
        end
      end
      default: begin
        // First length byte; unused codes restart the header here too.
        state_o.payload_length = {byte_i, 8'h00};
        state_o.phase          = PH_LEN_LO;
      end
    endcase

    // Frame completion: count it, and switch to passthrough at the limit.
    if (frame_done) begin
      if (frames_inc >= {1'b0, limit_i}) begin
        state_o.frames_seen = limit_i;
        state_o.phase       = PH_PASS;
      end else begin
        state_o.frames_seen = frames_inc[7:0];
        state_o.phase       = PH_LEN_HI;
      end
    end
  end

endmodule

`default_nettype wire

/* design/padded_frame_deframer.sv */
// Top level of the padded frame deframer: input register, parser state,
// result register and limit register.
// Depends on pfd_pkg, the interfaces in pfd_stream_if.sv and pfd_parser.
//
// Usage:
//   in_if carries one stream byte per transfer. Frames are a 2-byte
//   big-endian payload length, a 1-byte padding length, the payload and the
//   padding. out_if carries one transfer per payload byte, with
//   frame_payload_end on the last byte of each frame. Header and padding
//   bytes give no output. After padded_frame_limit frames every byte passes
//   through with is_passthrough set, until reset.
//   cfg_if writes padded_frame_limit and is always ready. The user must write it
//   only while no byte is in flight; the block itself does not enforce this.
//   A byte taken from in_if is held in the input register, parsed there by
//   the combinational parser, and its result is offered on out_if from the
//   result register. Throughput is one byte per cycle while out_if does not
//   stall. When out_if stalls, one more byte is held in the
//   input register and then in_if.ready drops; nothing is lost.
//   Reset (rst_ni low, asynchronous) empties both registers, restarts the
//   parser at the first length byte with no frames counted, and sets the
//   limit to 8.
`default_nettype none

module padded_frame_deframer
  import pfd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  pfd_in_if.sink   in_if,
  pfd_out_if.source out_if,
  pfd_cfg_if.sink  cfg_if
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  pfd_state_t  state_q, state_d;
  pfd_result_t result_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_end_q;
  logic        out_pass_q;
  logic [7:0]  limit_q;
  logic        advance;
  logic        in_xfer;

  // The parse stage moves when the result register is empty or draining.
  assign advance      = !out_valid_q || out_if.ready;
  assign in_if.ready  = !in_valid_q || advance;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // Input register valid tracking.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_if.in_byte;
    end
  end

  // Parser for the byte in the input register.
  pfd_parser u_parser (
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .limit_i  (limit_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Parser state and limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_LEN_HI, default: '0};
      limit_q <= PadLimitReset;
    end else begin
      if (in_valid_q && advance) begin
        state_q <= state_d;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        limit_q <= cfg_if.padded_frame_limit;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && result_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && result_d.valid) begin
      out_byte_q <= result_d.out_byte;
      out_end_q  <= result_d.frame_payload_end;
      out_pass_q <= result_d.is_passthrough;
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.out_byte          = out_byte_q;
  assign out_if.frame_payload_end = out_end_q;
  assign out_if.is_passthrough    = out_pass_q;

  // Passthrough is left only by reset.
  a_pass_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_PASS |=> state_q.phase == PH_PASS)
    else $error("passthrough phase was left");

  // A passthrough result never carries an end-of-frame flag.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_end_q && out_pass_q))
    else $error("end flag on a passthrough byte");

  // A passthrough result can only come from the passthrough phase.
  a_pass_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pass_q |-> state_q.phase == PH_PASS)
    else $error("passthrough result outside passthrough phase");

  // The payload phase is entered only with a nonzero length.
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_PAYLOAD |-> state_q.payload_length != 16'd0)
    else $error("payload phase with zero length");

endmodule

`default_nettype wire
